FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the sts_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is active (rst_n low)
`define STS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define STS_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, reset values and the side-band type of the projection lanes.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Normalized magnitude width: the largest component lies in [2^29, 2^30)
  localparam int NORM_W     = 30;
  localparam int SQ_W       = 2 * NORM_W;
  // Radicand and root datapath of the digit-by-digit square root
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = 32;
  // Scale register
  localparam int SCALE_W    = 13;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd500;

  // Data that rides along the square root pipeline
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   zero;
  } side_t;

endpackage

FILE: rtl/sts_sqrt.sv
// ----------------------------------------------------------------------------
// sts_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sts_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [sts_pkg::RAD_W-1:0]       in_rad,
  input  sts_pkg::side_t                  in_side,
  output logic                            out_valid,
  output logic [sts_pkg::ROOT_W-1:0]      out_root,
  output sts_pkg::side_t                  out_side
);

  localparam int N  = sts_pkg::SQRT_STEPS;
  localparam int RW = sts_pkg::RAD_W;

  logic                vld_r  [0:N-1];
  logic [RW-1:0]       rem_r  [0:N-1];
  logic [RW-1:0]       res_r  [0:N-1];
  sts_pkg::side_t      side_r [0:N-1];

  genvar k;
  for (k = 0; k < N; k++) begin : g_step
    localparam logic [RW-1:0] STEP_BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * k);

    logic           vld_prev;
    logic [RW-1:0]  rem_prev;
    logic [RW-1:0]  res_prev;
    sts_pkg::side_t side_prev;
    logic [RW-1:0]  trial;
    logic           fits;
    logic [RW-1:0]  rem_nxt;
    logic [RW-1:0]  res_nxt;

    if (k == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = in_rad;
      assign res_prev  = '0;
      assign side_prev = in_side;
    end else begin : g_next
      assign vld_prev  = vld_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign res_prev  = res_r[k-1];
      assign side_prev = side_r[k-1];
    end

    // Try the next root digit; keep it if the remainder covers it
    assign trial   = res_prev + STEP_BIT;
    assign fits    = rem_prev >= trial;
    assign rem_nxt = fits ? (rem_prev - trial) : rem_prev;
    assign res_nxt = fits ? ((res_prev >> 1) + STEP_BIT) : (res_prev >> 1);

    // Advance valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end

    // Advance payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= side_prev;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = res_r[N-1][sts_pkg::ROOT_W-1:0];
  assign out_side  = side_r[N-1];

endmodule

FILE: rtl/sts_proj.sv
// ----------------------------------------------------------------------------
// sts_proj
// Projection lane: normalizes a point, takes the root of its squared length
// and divides each scaled component by it, rounding and saturating.
// ----------------------------------------------------------------------------
module sts_proj #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [2:0][COORD_WIDTH:0]         in_pt,
  input  logic [sts_pkg::SCALE_W-1:0]       scale,
  output logic                              out_valid,
  output logic [2:0][COORD_WIDTH-1:0]       out_pt
);

  localparam int NW   = sts_pkg::NORM_W;
  localparam int MW   = COORD_WIDTH + 1;
  localparam int LZL  = $clog2(MW);
  localparam int QW   = FRAC_BITS + 12;
  localparam int DW   = FRAC_BITS + 44;
  localparam int PMW  = sts_pkg::NORM_W + sts_pkg::SCALE_W;
  localparam int RTW  = sts_pkg::ROOT_W;
  localparam int CMPW = ((QW > COORD_WIDTH) ? QW : COORD_WIDTH) + 1;
  localparam logic [CMPW-1:0] MAX_NEG = {{(CMPW-1){1'b0}}, 1'b1} << (COORD_WIDTH - 1);
  localparam logic [CMPW-1:0] MAX_POS = MAX_NEG - {{(CMPW-1){1'b0}}, 1'b1};

  // --------------------------------------------------------------------------
  // Magnitude and sign
  // --------------------------------------------------------------------------
  logic [2:0][MW-1:0] mag_a_nxt;
  logic [2:0]         neg_a_nxt;
  logic               a_vld_r;
  logic [2:0][MW-1:0] a_mag_r;
  logic [2:0]         a_neg_r;
  logic               a_zero_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      neg_a_nxt[c] = in_pt[c][COORD_WIDTH];
      mag_a_nxt[c] = neg_a_nxt[c] ? (~in_pt[c] + 1'b1) : in_pt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= mag_a_nxt;
      a_neg_r  <= neg_a_nxt;
      a_zero_r <= (mag_a_nxt[0] | mag_a_nxt[1] | mag_a_nxt[2]) == '0;
    end
  end

  // --------------------------------------------------------------------------
  // Normalize: shift all three left by a binary-weighted amount per stage
  // until the largest has its top bit set
  // --------------------------------------------------------------------------
  logic               nrm_vld_r  [0:LZL-1];
  logic [2:0][MW-1:0] nrm_mag_r  [0:LZL-1];
  logic [2:0]         nrm_neg_r  [0:LZL-1];
  logic               nrm_zero_r [0:LZL-1];

  genvar j;
  for (j = 0; j < LZL; j++) begin : g_norm
    localparam int SH = 1 << (LZL - 1 - j);

    logic               vld_prev;
    logic [2:0][MW-1:0] mag_prev;
    logic [2:0]         neg_prev;
    logic               zero_prev;
    logic [MW-1:0]      orv;
    logic [2:0][MW-1:0] mag_nxt;

    if (j == 0) begin : g_first
      assign vld_prev  = a_vld_r;
      assign mag_prev  = a_mag_r;
      assign neg_prev  = a_neg_r;
      assign zero_prev = a_zero_r;
    end else begin : g_next
      assign vld_prev  = nrm_vld_r[j-1];
      assign mag_prev  = nrm_mag_r[j-1];
      assign neg_prev  = nrm_neg_r[j-1];
      assign zero_prev = nrm_zero_r[j-1];
    end

    assign orv = mag_prev[0] | mag_prev[1] | mag_prev[2];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        mag_nxt[c] = (orv[MW-1 -: SH] == '0) ? (mag_prev[c] << SH) : mag_prev[c];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nrm_vld_r[j] <= 1'b0;
      end else if (en) begin
        nrm_vld_r[j] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm_mag_r[j]  <= mag_nxt;
        nrm_neg_r[j]  <= neg_prev;
        nrm_zero_r[j] <= zero_prev;
      end
    end
  end

  // Take the top bits (truncating) or pad on the right
  logic [2:0][NW-1:0] nx;

  if (MW >= NW) begin : g_trunc
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        nx[c] = nrm_mag_r[LZL-1][c][MW-1 -: NW];
      end
    end
  end else begin : g_pad
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        nx[c] = {nrm_mag_r[LZL-1][c], {(NW - MW){1'b0}}};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Squares, then their sum
  // --------------------------------------------------------------------------
  logic                               sq_vld_r;
  logic [2:0][sts_pkg::SQ_W-1:0]      sq_r;
  sts_pkg::side_t                     sq_side_r;
  sts_pkg::side_t                     sq_side_nxt;
  logic                               sum_vld_r;
  logic [sts_pkg::RAD_W-1:0]          rad_r;
  sts_pkg::side_t                     sum_side_r;

  always_comb begin
    sq_side_nxt.mag  = nx;
    sq_side_nxt.neg  = nrm_neg_r[LZL-1];
    sq_side_nxt.zero = nrm_zero_r[LZL-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      sum_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r  <= nrm_vld_r[LZL-1];
      sum_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= nx[c] * nx[c];
      end
      sq_side_r  <= sq_side_nxt;
      rad_r      <= sts_pkg::RAD_W'(sq_r[0]) + sts_pkg::RAD_W'(sq_r[1])
                  + sts_pkg::RAD_W'(sq_r[2]);
      sum_side_r <= sq_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square root
  // --------------------------------------------------------------------------
  logic           rt_vld;
  logic [RTW-1:0] rt_root;
  sts_pkg::side_t rt_side;

  sts_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sum_vld_r),
    .in_rad    (rad_r),
    .in_side   (sum_side_r),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // --------------------------------------------------------------------------
  // Scale the magnitudes, then build dividend and divisor
  // dividend = m*scale*2^FRAC_BITS + 2r, divisor = 4r (rounds half up)
  // --------------------------------------------------------------------------
  logic                mul_vld_r;
  logic [2:0][PMW-1:0] mul_pm_r;
  logic [RTW-1:0]      mul_root_r;
  logic [2:0]          mul_neg_r;
  logic                mul_zero_r;
  logic                dv_vld_r;
  logic [2:0][DW-1:0]  dv_rem_r;
  logic [RTW+1:0]      dv_den_r;
  logic [2:0]          dv_neg_r;
  logic                dv_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      dv_vld_r  <= 1'b0;
    end else if (en) begin
      mul_vld_r <= rt_vld;
      dv_vld_r  <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mul_pm_r[c] <= PMW'(rt_side.mag[c]) * PMW'(scale);
        dv_rem_r[c] <= (DW'(mul_pm_r[c]) << FRAC_BITS) + DW'({mul_root_r, 1'b0});
      end
      mul_root_r <= rt_root;
      mul_neg_r  <= rt_side.neg;
      mul_zero_r <= rt_side.zero;
      dv_den_r   <= {mul_root_r, 2'b00};
      dv_neg_r   <= mul_neg_r;
      dv_zero_r  <= mul_zero_r;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring division, one quotient bit per stage, three components
  // --------------------------------------------------------------------------
  logic               div_vld_r  [0:QW-1];
  logic [2:0][DW-1:0] div_rem_r  [0:QW-1];
  logic [2:0][QW-1:0] div_q_r    [0:QW-1];
  logic [RTW+1:0]     div_den_r  [0:QW-1];
  logic [2:0]         div_neg_r  [0:QW-1];
  logic               div_zero_r [0:QW-1];

  genvar i;
  for (i = 0; i < QW; i++) begin : g_div
    localparam int B = QW - 1 - i;

    logic               vld_prev;
    logic [2:0][DW-1:0] rem_prev;
    logic [2:0][QW-1:0] q_prev;
    logic [RTW+1:0]     den_prev;
    logic [2:0]         neg_prev;
    logic               zero_prev;
    logic [DW-1:0]      shifted;
    logic [2:0][DW-1:0] rem_nxt;
    logic [2:0][QW-1:0] q_nxt;

    if (i == 0) begin : g_first
      assign vld_prev  = dv_vld_r;
      assign rem_prev  = dv_rem_r;
      assign q_prev    = '0;
      assign den_prev  = dv_den_r;
      assign neg_prev  = dv_neg_r;
      assign zero_prev = dv_zero_r;
    end else begin : g_next
      assign vld_prev  = div_vld_r[i-1];
      assign rem_prev  = div_rem_r[i-1];
      assign q_prev    = div_q_r[i-1];
      assign den_prev  = div_den_r[i-1];
      assign neg_prev  = div_neg_r[i-1];
      assign zero_prev = div_zero_r[i-1];
    end

    assign shifted = DW'(den_prev) << B;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (rem_prev[c] >= shifted) begin
          rem_nxt[c] = rem_prev[c] - shifted;
          q_nxt[c]   = {q_prev[c][QW-2:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_prev[c];
          q_nxt[c]   = {q_prev[c][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[i] <= 1'b0;
      end else if (en) begin
        div_vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_rem_r[i]  <= rem_nxt;
        div_q_r[i]    <= q_nxt;
        div_den_r[i]  <= den_prev;
        div_neg_r[i]  <= neg_prev;
        div_zero_r[i] <= zero_prev;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Apply sign, saturate, force a zero-length point to zero
  // --------------------------------------------------------------------------
  logic                        out_vld_r;
  logic [2:0][COORD_WIDTH-1:0] out_pt_r;
  logic [2:0][COORD_WIDTH-1:0] out_pt_nxt;

  always_comb begin
    logic [CMPW-1:0]        qe;
    logic                   negf;
    logic [COORD_WIDTH-1:0] mag_c;
    for (int c = 0; c < 3; c++) begin
      qe   = CMPW'(div_q_r[QW-1][c]);
      negf = div_neg_r[QW-1][c] && (qe != '0);
      if (negf) begin
        mag_c = (qe > MAX_NEG) ? MAX_NEG[COORD_WIDTH-1:0] : qe[COORD_WIDTH-1:0];
      end else begin
        mag_c = (qe > MAX_POS) ? MAX_POS[COORD_WIDTH-1:0] : qe[COORD_WIDTH-1:0];
      end
      if (div_zero_r[QW-1]) begin
        out_pt_nxt[c] = '0;
      end else if (negf) begin
        out_pt_nxt[c] = ~mag_c + 1'b1;
      end else begin
        out_pt_nxt[c] = mag_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= div_vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pt_r <= out_pt_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pt    = out_pt_r;

endmodule

FILE: rtl/sts_out.sv
// ----------------------------------------------------------------------------
// sts_out
// Gathers the six projected points of a triangle over three beats and
// serializes the four sub-triangles onto the result channel.
// ----------------------------------------------------------------------------
module sts_out #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              beat_valid,
  input  logic [2:0][COORD_WIDTH-1:0]       lane0_pt,
  input  logic [2:0][COORD_WIDTH-1:0]       lane1_pt,
  output logic                              beat_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_WIDTH-1:0]     out_p0_x,
  output logic signed [COORD_WIDTH-1:0]     out_p0_y,
  output logic signed [COORD_WIDTH-1:0]     out_p0_z,
  output logic signed [COORD_WIDTH-1:0]     out_p1_x,
  output logic signed [COORD_WIDTH-1:0]     out_p1_y,
  output logic signed [COORD_WIDTH-1:0]     out_p1_z,
  output logic signed [COORD_WIDTH-1:0]     out_p2_x,
  output logic signed [COORD_WIDTH-1:0]     out_p2_y,
  output logic signed [COORD_WIDTH-1:0]     out_p2_z,
  output logic                              out_last_triangle
);

  // Point slots
  localparam int PT_A  = 0;
  localparam int PT_B  = 1;
  localparam int PT_C  = 2;
  localparam int PT_AB = 3;
  localparam int PT_BC = 4;
  localparam int PT_CA = 5;

  // Gather beat count
  localparam logic [1:0] GAT_BEAT0 = 2'd0;
  localparam logic [1:0] GAT_BEAT1 = 2'd1;
  localparam logic [1:0] GAT_BEAT2 = 2'd2;
  localparam logic [1:0] GAT_FULL  = 2'd3;

  // Sub-triangle codes
  localparam logic [1:0] TRI_0    = 2'd0;
  localparam logic [1:0] TRI_1    = 2'd1;
  localparam logic [1:0] TRI_2    = 2'd2;
  localparam logic [1:0] TRI_LAST = 2'd3;

  logic [2:0][COORD_WIDTH-1:0] gat_pt_r [0:5];
  logic [1:0]                  gcnt_r;
  logic [2:0][COORD_WIDTH-1:0] ser_pt_r [0:5];
  logic                        ser_vld_r;
  logic [1:0]                  tri_r;

  logic take;
  logic out_acc;
  logic ser_free;
  logic xfer;

  assign beat_ready = gcnt_r != GAT_FULL;
  assign take       = beat_valid && beat_ready;
  assign out_acc    = ser_vld_r && !out_stall;
  assign ser_free   = !ser_vld_r || (out_acc && (tri_r == TRI_LAST));
  assign xfer       = (gcnt_r == GAT_FULL) && ser_free;

  // Gather: two points per beat
  always_ff @(posedge clk) begin
    if (take) begin
      case (gcnt_r)
        GAT_BEAT0: begin
          gat_pt_r[PT_A]  <= lane0_pt;
          gat_pt_r[PT_B]  <= lane1_pt;
        end
        GAT_BEAT1: begin
          gat_pt_r[PT_C]  <= lane0_pt;
          gat_pt_r[PT_AB] <= lane1_pt;
        end
        GAT_BEAT2: begin
          gat_pt_r[PT_BC] <= lane0_pt;
          gat_pt_r[PT_CA] <= lane1_pt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r <= GAT_BEAT0;
    end else if (xfer) begin
      gcnt_r <= GAT_BEAT0;
    end else if (take) begin
      gcnt_r <= gcnt_r + 2'd1;
    end
  end

  // Serializer: hand a full set over, then step through the four triangles
  always_ff @(posedge clk) begin
    if (xfer) begin
      ser_pt_r <= gat_pt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      tri_r     <= TRI_0;
    end else if (xfer) begin
      ser_vld_r <= 1'b1;
      tri_r     <= TRI_0;
    end else if (out_acc) begin
      if (tri_r == TRI_LAST) begin
        ser_vld_r <= 1'b0;
      end else begin
        tri_r <= tri_r + 2'd1;
      end
    end
  end

  // Select the vertices of the current sub-triangle
  logic [2:0][COORD_WIDTH-1:0] p0;
  logic [2:0][COORD_WIDTH-1:0] p1;
  logic [2:0][COORD_WIDTH-1:0] p2;

  always_comb begin
    p0 = ser_pt_r[PT_AB];
    p1 = ser_pt_r[PT_BC];
    p2 = ser_pt_r[PT_CA];
    case (tri_r)
      TRI_0: begin
        p0 = ser_pt_r[PT_A];
        p1 = ser_pt_r[PT_AB];
        p2 = ser_pt_r[PT_CA];
      end
      TRI_1: begin
        p0 = ser_pt_r[PT_CA];
        p1 = ser_pt_r[PT_BC];
        p2 = ser_pt_r[PT_C];
      end
      TRI_2: begin
        p0 = ser_pt_r[PT_AB];
        p1 = ser_pt_r[PT_B];
        p2 = ser_pt_r[PT_BC];
      end
      TRI_LAST: begin
        p0 = ser_pt_r[PT_AB];
        p1 = ser_pt_r[PT_BC];
        p2 = ser_pt_r[PT_CA];
      end
      default: ;
    endcase
  end

  assign out_valid         = ser_vld_r;
  assign out_p0_x          = p0[0];
  assign out_p0_y          = p0[1];
  assign out_p0_z          = p0[2];
  assign out_p1_x          = p1[0];
  assign out_p1_y          = p1[1];
  assign out_p1_z          = p1[2];
  assign out_p2_x          = p2[0];
  assign out_p2_y          = p2[1];
  assign out_p2_z          = p2[2];
  assign out_last_triangle = tri_r == TRI_LAST;

endmodule

FILE: rtl/sphere_triangle_subdivide.sv
// Each triangle gives four results, stepped out by the output serializer; the
// two projection lanes take it as three beats of two points, and the next
// triangle is accepted as the last beat of the one before it issues.
// Reset: synchronous, active low; empties the pipeline and loads scale 500.
// ----------------------------------------------------------------------------
// sphere_triangle_subdivide
// Splits a triangle into four and projects the six points onto a sphere of
// radius scale_r/4, through two pipelined projection lanes.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivide #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [sts_pkg::SCALE_W-1:0]       cfg_wr_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_a_x,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_a_y,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_a_z,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_b_x,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_b_y,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_b_z,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_c_x,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_c_y,
  input  logic signed [COORD_WIDTH-1:0]     in_corner_c_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_WIDTH-1:0]     out_p0_x,
  output logic signed [COORD_WIDTH-1:0]     out_p0_y,
  output logic signed [COORD_WIDTH-1:0]     out_p0_z,
  output logic signed [COORD_WIDTH-1:0]     out_p1_x,
  output logic signed [COORD_WIDTH-1:0]     out_p1_y,
  output logic signed [COORD_WIDTH-1:0]     out_p1_z,
  output logic signed [COORD_WIDTH-1:0]     out_p2_x,
  output logic signed [COORD_WIDTH-1:0]     out_p2_y,
  output logic signed [COORD_WIDTH-1:0]     out_p2_z,
  output logic                              out_last_triangle
);

  localparam int CW = COORD_WIDTH;

  // Issue beat codes
  localparam logic [1:0] BEAT_0    = 2'd0;
  localparam logic [1:0] BEAT_1    = 2'd1;
  localparam logic [1:0] BEAT_LAST = 2'd2;

  // --------------------------------------------------------------------------
  // Scale register
  // --------------------------------------------------------------------------
  logic [sts_pkg::SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= sts_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Input hold and issue: two points per beat, three beats per item
  // --------------------------------------------------------------------------
  logic                   hold_vld_r;
  logic [1:0]             beat_r;
  logic [2:0][2:0][CW-1:0] hold_pt_r;

  logic en;
  logic issue;
  logic done;
  logic in_acc;
  logic [1:0] lane_vld;
  logic tail_vld;
  logic beat_ready;

  assign tail_vld = lane_vld[0] & lane_vld[1];
  assign en       = !(tail_vld && !beat_ready);
  assign issue    = hold_vld_r && en;
  assign done     = issue && (beat_r == BEAT_LAST);
  assign in_stall = hold_vld_r && !done;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      beat_r     <= BEAT_0;
    end else begin
      if (in_acc) begin
        hold_vld_r <= 1'b1;
      end else if (done) begin
        hold_vld_r <= 1'b0;
      end
      if (done) begin
        beat_r <= BEAT_0;
      end else if (issue) begin
        beat_r <= beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_pt_r[0] <= {in_corner_a_z, in_corner_a_y, in_corner_a_x};
      hold_pt_r[1] <= {in_corner_b_z, in_corner_b_y, in_corner_b_x};
      hold_pt_r[2] <= {in_corner_c_z, in_corner_c_y, in_corner_c_x};
    end
  end

  // Corners sign-extended; midpoints kept as plain sums (direction only)
  logic [2:0][CW:0] pa, pb, pc, pab, pbc, pca;
  logic [2:0][CW:0] lane0_in, lane1_in;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pa[c]  = {hold_pt_r[0][c][CW-1], hold_pt_r[0][c]};
      pb[c]  = {hold_pt_r[1][c][CW-1], hold_pt_r[1][c]};
      pc[c]  = {hold_pt_r[2][c][CW-1], hold_pt_r[2][c]};
      pab[c] = pa[c] + pb[c];
      pbc[c] = pb[c] + pc[c];
      pca[c] = pc[c] + pa[c];
    end
  end

  always_comb begin
    case (beat_r)
      BEAT_0: begin
        lane0_in = pa;
        lane1_in = pb;
      end
      BEAT_1: begin
        lane0_in = pc;
        lane1_in = pab;
      end
      BEAT_LAST: begin
        lane0_in = pbc;
        lane1_in = pca;
      end
      default: begin
        lane0_in = '0;
        lane1_in = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Projection lanes
  // --------------------------------------------------------------------------
  logic [2:0][CW-1:0] lane0_out, lane1_out;

  sts_proj #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_proj0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (hold_vld_r),
    .in_pt     (lane0_in),
    .scale     (scale_r),
    .out_valid (lane_vld[0]),
    .out_pt    (lane0_out)
  );

  sts_proj #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_proj1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (hold_vld_r),
    .in_pt     (lane1_in),
    .scale     (scale_r),
    .out_valid (lane_vld[1]),
    .out_pt    (lane1_out)
  );

  // --------------------------------------------------------------------------
  // Gather and serialize
  // --------------------------------------------------------------------------
  sts_out #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .beat_valid        (tail_vld),
    .lane0_pt          (lane0_out),
    .lane1_pt          (lane1_out),
    .beat_ready        (beat_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_p0_x          (out_p0_x),
    .out_p0_y          (out_p0_y),
    .out_p0_z          (out_p0_z),
    .out_p1_x          (out_p1_x),
    .out_p1_y          (out_p1_y),
    .out_p1_z          (out_p1_z),
    .out_p2_x          (out_p2_x),
    .out_p2_y          (out_p2_y),
    .out_p2_z          (out_p2_z),
    .out_last_triangle (out_last_triangle)
  );

endmodule

FILE: rtl/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks: result hold under stall, four results per item with
// the last flag on the fourth, and quiet output out of reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sts_checker #(
  parameter int COORD_WIDTH = 20
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_WIDTH-1:0] out_p0_x,
  input logic signed [COORD_WIDTH-1:0] out_p1_y,
  input logic signed [COORD_WIDTH-1:0] out_p2_z,
  input logic                          out_last_triangle
);

  localparam logic [1:0] LAST_SLOT = 2'd3;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] ocnt_r;
  logic [9:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track position within each group of four results and results owed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
      pend_r <= '0;
    end else begin
      if (out_acc) begin
        ocnt_r <= ocnt_r + 2'd1;
      end
      pend_r <= pend_r + (in_acc ? 10'd4 : 10'd0) - (out_acc ? 10'd1 : 10'd0);
    end
  end

  `STS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_p0_x) && $stable(out_p1_y) && $stable(out_p2_z), "stalled result changed")
  `STS_ASSERT(a_last_slot, clk, rst_n, out_valid |-> (out_last_triangle == (ocnt_r == LAST_SLOT)), "last flag off the fourth result")
  `STS_ASSERT(a_no_extra, clk, rst_n, out_valid |-> (pend_r != '0), "result without a pending item")
  `STS_ASSERT_NORST(a_reset_quiet, clk, ($past(rst_n) == 1'b0) |-> !out_valid, "result valid right after reset")

endmodule

bind sphere_triangle_subdivide sts_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sts_checker (.*);

FILE: tb/subdivide_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subdivide_checker
// Watches the triangle and result channels of the subdivider, predicts the
// four projected sub-triangles of every accepted item and compares each
// accepted result with the oldest pending prediction.
// ----------------------------------------------------------------------------
module subdivide_checker #(
  parameter int CW = 20,
  parameter int FB = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sts_pkg::SCALE_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [8:0][CW-1:0]           in_corners,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [8:0][CW-1:0]           out_verts,
  input  logic                         out_last,
  output int                           fail_count,
  output int                           pending,
  output int                           tri_done
);

  typedef struct packed {
    logic [8:0][CW-1:0] crd;
    logic               last;
  } subtri_t;

  // vertex ids: 0=a 1=b 2=c 3=ab 4=bc 5=ca
  localparam int SPLIT_ORDER [4][3] = '{'{0, 3, 5}, '{5, 4, 2}, '{3, 1, 4}, '{3, 4, 5}};

  subtri_t                     subtri_q[$];
  logic [sts_pkg::SCALE_W-1:0] scale;

  // Saturate a magnitude with sign into a coordinate field
  function automatic logic [CW-1:0] sat_coord(logic [63:0] mag, logic neg);
    logic [63:0] lim;
    lim = 64'd1 << (CW - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      return CW'(-mag);
    end
    if (mag > lim - 1) mag = lim - 1;
    return CW'(mag);
  endfunction

  // Project one point onto the sphere of radius scale/4
  function automatic logic [2:0][CW-1:0] project_point(logic signed [2:0][CW:0] v,
                                                       logic [sts_pkg::SCALE_W-1:0] sc);
    logic [63:0]        m [3];
    logic               ng [3];
    logic signed [63:0] s;
    logic [63:0]        top, n2, root, bitv, den, num, q;
    logic [2:0][CW-1:0] o;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      s = $signed(v[i]);
      ng[i] = s < 0;
      m[i] = ng[i] ? -s : s;
      if (m[i] > top) top = m[i];
    end
    o = '0;
    if (top == 0 || sc == 0) return o;
    // normalize the largest magnitude into [2^29, 2^30)
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    n2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    // digit-by-digit integer square root
    root = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n2 >= root + bitv) begin
        n2 = n2 - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    den = root << 2;
    for (int i = 0; i < 3; i++) begin
      num = (m[i] * sc) << FB;
      q = (2 * num + den) / (2 * den);
      o[i] = sat_coord(q, ng[i] && q != 0);
    end
    return o;
  endfunction

  // Queue the four sub-triangles of one accepted triangle
  task automatic predict_split(logic [8:0][CW-1:0] c);
    logic signed [5:0][2:0][CW:0] pt;
    logic [5:0][2:0][CW-1:0]      pr;
    subtri_t                      t;
    for (int j = 0; j < 3; j++) begin
      pt[0][j] = $signed(c[j]);
      pt[1][j] = $signed(c[3 + j]);
      pt[2][j] = $signed(c[6 + j]);
      pt[3][j] = $signed(pt[0][j]) + $signed(pt[1][j]);
      pt[4][j] = $signed(pt[1][j]) + $signed(pt[2][j]);
      pt[5][j] = $signed(pt[2][j]) + $signed(pt[0][j]);
    end
    for (int i = 0; i < 6; i++) pr[i] = project_point(pt[i], scale);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          t.crd[i * 3 + j] = pr[SPLIT_ORDER[k][i]][j];
      t.last = (k == 3);
      subtri_q.push_back(t);
    end
  endtask

  initial begin
    fail_count = 0;
    tri_done = 0;
    scale = sts_pkg::SCALE_RESET;
  end

  assign pending = subtri_q.size();

  // Track the scale register, predict on input, compare on output
  always @(posedge clk) begin
    subtri_t exp_t;
    if (!rst_n) begin
      scale = sts_pkg::SCALE_RESET;
      subtri_q.delete();
    end else begin
      if (cfg_wr_en) scale = cfg_wr_data;
      if (in_valid && !in_stall) predict_split(in_corners);
      if (out_valid && !out_stall) begin
        tri_done++;
        if (subtri_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: result with no pending item at %0t", $time);
        end else begin
          exp_t = subtri_q.pop_front();
          for (int f = 0; f < 9; f++) begin
            if (out_verts[f] !== exp_t.crd[f]) begin
              fail_count++;
              if (fail_count <= 10)
                $display("ERROR: vertex %0d coord %0d exp %0d got %0d at %0t", f / 3, f % 3,
                         $signed(exp_t.crd[f]), $signed(out_verts[f]), $time);
            end
          end
          if (out_last !== exp_t.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: last flag exp %0b got %0b at %0t", exp_t.last, out_last, $time);
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives triangles through the sphere subdivider under several scale
// settings, with random gaps and stalls on both channels, and reports the
// verdict from the checker's failure count and its pending results.
// ----------------------------------------------------------------------------
module tb;

  localparam int CW        = 20;
  localparam int WD_LIMIT  = 3000;
  localparam int DRAIN_CYC = 100;
  localparam int HOLD_CYC  = 400;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [sts_pkg::SCALE_W-1:0] cfg_wr_data;
  logic                        in_valid, in_stall;
  logic [8:0][CW-1:0]          in_corners;
  logic                        out_valid, out_stall;
  logic [8:0][CW-1:0]          out_verts;
  logic                        out_last;
  int                          fail_count, pending, tri_done;
  int                          tx_max, rx_max, idle_cnt, items_sent, scale_writes;
  logic                        hold_req;

  sphere_triangle_subdivide #(.COORD_WIDTH(CW), .FRAC_BITS(8)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_corner_a_x(in_corners[0]), .in_corner_a_y(in_corners[1]),
    .in_corner_a_z(in_corners[2]), .in_corner_b_x(in_corners[3]),
    .in_corner_b_y(in_corners[4]), .in_corner_b_z(in_corners[5]),
    .in_corner_c_x(in_corners[6]), .in_corner_c_y(in_corners[7]),
    .in_corner_c_z(in_corners[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_p0_x(out_verts[0]), .out_p0_y(out_verts[1]), .out_p0_z(out_verts[2]),
    .out_p1_x(out_verts[3]), .out_p1_y(out_verts[4]), .out_p1_z(out_verts[5]),
    .out_p2_x(out_verts[6]), .out_p2_y(out_verts[7]), .out_p2_z(out_verts[8]),
    .out_last_triangle(out_last)
  );

  subdivide_checker #(.CW(CW), .FB(8)) u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_corners(in_corners),
    .out_valid(out_valid), .out_stall(out_stall), .out_verts(out_verts),
    .out_last(out_last), .fail_count(fail_count), .pending(pending),
    .tri_done(tri_done)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Count cycles with no item moving on either channel; fail once WD_LIMIT is reached
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WD_LIMIT) begin
      $display("FAIL sphere_triangle_subdivide");
      $finish;
    end
  end

  // Result side: random stalls, with an optional long hold-off
  initial begin
    int w;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 0;
      end
      w = $urandom_range(0, rx_max);
      if (w > 0) begin
        out_stall = 1;
        repeat (w) @(negedge clk);
      end
      out_stall = 0;
      #1;
      while (!out_valid) begin
        @(negedge clk);
        #1;
      end
      @(posedge clk);
    end
  end

  // Pick one coordinate, mostly spread over magnitudes
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 511)) - 256);
      2: return CW'($signed(CW'($urandom)) >>> $urandom_range(0, CW - 1));
      3: return $urandom_range(0, 1) ? CW'(1 << (CW - 1)) : CW'((1 << (CW - 1)) - 1);
      default: return CW'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Offer one triangle after a random gap and hold it until accepted
  task automatic send_tri(logic [8:0][CW-1:0] c);
    int g;
    g = $urandom_range(0, tx_max);
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_corners = c;
    in_valid = 1;
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    in_valid = 0;
    items_sent++;
  endtask

  task automatic send_random(int n);
    logic [8:0][CW-1:0] c;
    repeat (n) begin
      for (int f = 0; f < 9; f++) c[f] = rand_coord();
      send_tri(c);
    end
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain();
    int n;
    n = 0;
    while (pending != 0 && n < 50000) begin
      @(negedge clk);
      n++;
    end
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_scale(logic [sts_pkg::SCALE_W-1:0] v);
    drain();
    cfg_wr_en = 1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 0;
    scale_writes++;
  endtask

  localparam logic [CW-1:0] CMAX = (1 << (CW - 1)) - 1;
  localparam logic [CW-1:0] CMIN = 1 << (CW - 1);

  initial begin
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_valid = 0;
    in_corners = '0;
    hold_req = 0;
    tx_max = 13;
    rx_max = 13;
    idle_cnt = 0;
    items_sent = 0;
    scale_writes = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;

    // Directed: zero points, opposite corners, extremes, axes, tiny values
    send_tri('0);
    send_tri({CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    send_tri({CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    send_tri({CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN});
    send_tri({CW'(0), CW'(0), CW'(256), CW'(0), CW'(256), CW'(0),
              CW'(0), CW'(0), CW'(256)});
    send_tri({CW'(-5), CW'(3), CW'(-1), CW'(5), CW'(-3), CW'(1),
              CW'(0), CW'(0), CW'(1)});
    send_tri({CW'(1), CW'(0), CW'(0), CW'(0), CW'(1), CW'(0),
              CW'(0), CW'(0), CW'(1)});
    send_tri({CW'(-1), CW'(-1), CW'(-1), CW'(0), CW'(0), CW'(0),
              CMIN, CW'(0), CW'(0)});
    send_tri({CMAX, CW'(0), CW'(0), CMIN, CW'(0), CW'(0),
              CW'(0), CMAX, CMIN});
    send_tri({CW'(1000), CW'(-2000), CW'(3000), CW'(-1000), CW'(2000), CW'(-3000),
              CW'(7), CW'(7), CW'(-7)});
    send_random(60);

    // Largest radius, with a long hold-off on the result side
    write_scale(13'd8191);
    send_tri({CMAX, CW'(0), CW'(0), CW'(0), CMIN, CW'(0), CW'(0), CW'(0), CMAX});
    hold_req = 1;
    tx_max = 0;
    send_random(40);
    tx_max = 13;
    send_random(30);

    // Smallest radius, no idling on either side
    write_scale(13'd1);
    tx_max = 0;
    rx_max = 0;
    send_random(70);
    tx_max = 13;
    rx_max = 13;

    write_scale(13'd4);
    send_random(60);

    write_scale(13'($urandom_range(1, 8191)));
    send_random(70);

    write_scale(13'd500);
    send_random(70);

    drain();
    $display("Sent %0d triangles, checked %0d sub-triangles over %0d scale writes.",
             items_sent, tri_done, scale_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sphere_triangle_subdivide");
    end else begin
      $display("FAIL sphere_triangle_subdivide");
    end
    $finish;
  end

endmodule
